// File: rtl/sfsa_pkg.sv
// Shared types and codes of the sample filter splat accumulator.
// No dependencies; sfsa_if and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package sfsa_pkg;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INDEX   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_HALF_WIDTH  = 3'd0,
    REG_TABLE_SCALE = 3'd1,
    REG_CLAMP       = 3'd2,
    REG_ORIGIN_X    = 3'd3,
    REG_ORIGIN_Y    = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SETUP,
    S_IDX_MUL,
    S_IDX_CHK,
    S_PIX_RD,
    S_PIX_LAT,
    S_PIX_MUL,
    S_PIX_WR,
    S_READ,
    S_READ_LAT,
    S_DONE
  } state_t;

  localparam int unsigned SUM_W    = 40;
  localparam int unsigned WSUM_W   = 32;
  localparam int unsigned WEIGHT_W = 18;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned FILM_WORD_W = 4 * SUM_W + WSUM_W;

  localparam logic [COLOR_W-1:0] COLOR_ONE = 16'd4096;
  localparam logic [11:0] HW_MIN = 12'd128;

endpackage

// File: rtl/sfsa_if.sv
// Handshake channels of the sample filter splat accumulator: input items,
// result items and configuration writes. Uses sfsa_pkg for field widths.
`timescale 1ns / 1ps

interface sfsa_item_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            operation;
  logic [11:0]                           pixel_x;
  logic [11:0]                           pixel_y;
  logic [7:0]                            sub_x;
  logic [7:0]                            sub_y;
  logic [sfsa_pkg::COLOR_W-1:0]          red;
  logic [sfsa_pkg::COLOR_W-1:0]          green;
  logic [sfsa_pkg::COLOR_W-1:0]          blue;
  logic [sfsa_pkg::COLOR_W-1:0]          alpha;
  logic [7:0]                            table_address;
  logic signed [sfsa_pkg::WEIGHT_W-1:0]  table_weight;

  modport source (output valid, operation, pixel_x, pixel_y, sub_x, sub_y, red, green,
                  blue, alpha, table_address, table_weight, input ready);
  modport sink (input valid, operation, pixel_x, pixel_y, sub_x, sub_y, red, green,
                blue, alpha, table_address, table_weight, output ready);
endinterface

interface sfsa_result_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [sfsa_pkg::SUM_W-1:0]   sum_red;
  logic signed [sfsa_pkg::SUM_W-1:0]   sum_green;
  logic signed [sfsa_pkg::SUM_W-1:0]   sum_blue;
  logic signed [sfsa_pkg::SUM_W-1:0]   sum_alpha;
  logic signed [sfsa_pkg::WSUM_W-1:0]  sum_weight;

  modport source (output valid, status, sum_red, sum_green, sum_blue, sum_alpha,
                  sum_weight, input ready);
  modport sink (input valid, status, sum_red, sum_green, sum_blue, sum_alpha,
                sum_weight, output ready);
endinterface

interface sfsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/sfsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sfsa_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sfsa_mul.sv
// Shared registered signed multiplier of the accumulator's sequencer.
// No dependencies.
`timescale 1ns / 1ps

module sfsa_mul (
  input  logic               clk,
  input  logic signed [16:0] a,
  input  logic signed [17:0] b,
  output logic signed [34:0] p
);

  always_ff @(posedge clk) begin
    p <= 35'(a) * 35'(b);
  end

endmodule

// File: rtl/sample_filter_splat_accumulator.sv
// Top level of the sample filter splat accumulator: sequencer, film and table RAMs.
// Depends on sfsa_pkg, sfsa_if, sfsa_ram and sfsa_mul.
//
//   channel  role    transaction
//   item     sink    operation with pixel, subpixel, colour and table fields
//   result   source  status and the five sums, one per item
//   cfg      sink    register index and write data, always ready
//
// A table load passes through decode and done, and a pixel read through decode,
// read, read latency and done. A sample add runs axis setup, then a multiply and
// a check per tap of both axes, then per covered pixel a read, a latency step, a
// multiply per channel and a write-back. It runs on the one shared multiplier
// and the film RAM's single read port. After reset a clearing pass zeroes both
// memories; no item is taken meanwhile.
// A finished result waits in an output register while the next item is accepted.
`timescale 1ns / 1ps

module sample_filter_splat_accumulator #(
  parameter int unsigned FILM_WIDTH  = 64,
  parameter int unsigned FILM_HEIGHT = 64,
  parameter int unsigned TABLE_DIM   = 16,
  parameter int unsigned MAX_TAPS    = 8
) (
  input  logic         clk,
  input  logic         rst,
  sfsa_cfg_if.sink     cfg,
  sfsa_item_if.sink    item,
  sfsa_result_if.source result
);

  localparam int unsigned FILM_SIZE  = FILM_WIDTH * FILM_HEIGHT;
  localparam int unsigned TABLE_SIZE = TABLE_DIM * TABLE_DIM;
  localparam int unsigned CLR_LEN    = (FILM_SIZE > TABLE_SIZE) ? FILM_SIZE : TABLE_SIZE;
  localparam int unsigned AW   = $clog2(FILM_SIZE);
  localparam int unsigned TW   = $clog2(TABLE_SIZE);
  localparam int unsigned CLRW = $clog2(CLR_LEN);
  localparam int unsigned XW   = $clog2(FILM_WIDTH);
  localparam int unsigned YW   = $clog2(FILM_HEIGHT);
  localparam int unsigned IDXW = $clog2(TABLE_DIM);
  localparam int unsigned TIW  = $clog2(MAX_TAPS);
  localparam int unsigned TCW  = $clog2(MAX_TAPS + 1);
  localparam int unsigned SUM_W  = sfsa_pkg::SUM_W;
  localparam int unsigned WSUM_W = sfsa_pkg::WSUM_W;
  localparam logic [11:0] HW_MAX = 12'(MAX_TAPS * 128);

  sfsa_pkg::state_t state, state_next;

  // Configuration registers.
  logic [10:0] half_width;
  logic [15:0] table_scale;
  logic        clamp_enable;
  logic [11:0] origin_x;
  logic [11:0] origin_y;

  // Latched item.
  logic [1:0]  op;
  logic [11:0] px, py;
  logic [7:0]  sx, sy;
  logic [15:0] col [4];
  logic [7:0]  taddr;
  logic signed [17:0] tweight;

  logic [CLRW-1:0] clr_cnt;
  logic            ax;
  logic [TIW-1:0]  n;
  logic [TIW-1:0]  ta, tb;
  logic [2:0]      ch;

  logic signed [15:0] first_x, first_y;
  logic [TCW-1:0]     cnt_x, cnt_y;
  logic [XW-1:0]      start_x;
  logic [YW-1:0]      start_y;
  logic [IDXW-1:0]    xi [MAX_TAPS];
  logic [IDXW-1:0]    yi [MAX_TAPS];

  logic signed [SUM_W-1:0]  acc [4];
  logic signed [WSUM_W-1:0] accw;
  logic signed [17:0]       wt;
  logic [AW-1:0]            rd_addr;

  logic [1:0]               res_status;
  logic signed [SUM_W-1:0]  res_sum [4];
  logic signed [WSUM_W-1:0] res_w;

  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [SUM_W-1:0]  out_sum [4];
  logic signed [WSUM_W-1:0] out_w;

  // Memories and multiplier.
  logic                    tab_we;
  logic [TW-1:0]           tab_waddr, tab_raddr;
  logic [17:0]             tab_wdata, tab_rdata;
  logic                    film_we;
  logic [AW-1:0]           film_waddr, film_raddr;
  logic [sfsa_pkg::FILM_WORD_W-1:0] film_wdata, film_rdata;
  logic signed [16:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic signed [34:0]      mul_p;

  sfsa_ram #(.WIDTH(18), .DEPTH(TABLE_SIZE)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  sfsa_ram #(.WIDTH(sfsa_pkg::FILM_WORD_W), .DEPTH(FILM_SIZE)) u_film (
    .clk(clk), .we(film_we), .waddr(film_waddr), .wdata(film_wdata),
    .raddr(film_raddr), .rdata(film_rdata)
  );

  sfsa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] x,
                                                      logic signed [34:0] y);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(x) + (SUM_W+1)'(y);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic signed [WSUM_W-1:0] sat_wsum(logic signed [WSUM_W-1:0] x,
                                                        logic signed [17:0] y);
    logic signed [WSUM_W:0] s;
    s = (WSUM_W+1)'(x) + (WSUM_W+1)'(y);
    if (s[WSUM_W] != s[WSUM_W-1]) begin
      return s[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
    end
    return s[WSUM_W-1:0];
  endfunction

  // Axis setup, shared by both axes: rounded footprint clipped to the film and to MAX_TAPS taps.
  logic [11:0]        hw_sat;
  logic [11:0]        ax_pix, ax_org;
  logic [7:0]         ax_sub;
  logic signed [15:0] ax_len, s16, hw16, d0, d1, lo, hi, c0, c1, span, start_rel;
  logic [TCW-1:0]     ax_new_cnt;

  always_comb begin
    hw_sat = {1'b0, half_width};
    if (hw_sat < sfsa_pkg::HW_MIN) hw_sat = sfsa_pkg::HW_MIN;
    if (hw_sat > HW_MAX) hw_sat = HW_MAX;
    ax_pix = ax ? py : px;
    ax_org = ax ? origin_y : origin_x;
    ax_sub = ax ? sy : sx;
    ax_len = ax ? 16'(FILM_HEIGHT) : 16'(FILM_WIDTH);
    s16  = signed'({8'd0, ax_sub});
    hw16 = signed'({4'd0, hw_sat});
    d0 = (s16 - hw16 + 16'sd128) >>> 8;
    d1 = (s16 + hw16 - 16'sd128) >>> 8;
    lo = signed'({4'd0, ax_org}) - signed'({4'd0, ax_pix});
    hi = signed'({4'd0, ax_org}) + ax_len - signed'({4'd0, ax_pix}) - 16'sd1;
    c0 = (d0 < lo) ? lo : d0;
    c1 = (d1 > hi) ? hi : d1;
    span = c1 - c0 + 16'sd1;
    if (c0 > c1) begin
      ax_new_cnt = '0;
    end else if (span > signed'(16'(MAX_TAPS))) begin
      ax_new_cnt = TCW'(MAX_TAPS);
    end else begin
      ax_new_cnt = TCW'(span);
    end
    start_rel = c0 + signed'({4'd0, ax_pix}) - signed'({4'd0, ax_org});
  end

  // Tap offset and index check.
  logic signed [15:0] ax_first, tap_t, tap_abs;
  logic [TCW-1:0]     ax_cnt;
  logic               idx_err, last_tap, ax_empty;

  always_comb begin
    ax_first = ax ? first_y : first_x;
    ax_cnt   = ax ? cnt_y : cnt_x;
    tap_t    = ((ax_first + signed'(16'(n))) <<< 8) - signed'({8'd0, ax_sub}) + 16'sd128;
    tap_abs  = tap_t[15] ? -tap_t : tap_t;
    idx_err  = mul_p[34:19] > 16'(TABLE_DIM - 1);
    last_tap = (TCW'(n) + TCW'(1)) == ax_cnt;
    ax_empty = ax_cnt == '0;
  end

  logic [YW-1:0] row;
  logic [XW-1:0] colm;
  logic [AW-1:0] pix_addr;
  logic          last_a, last_b, read_out;
  logic signed [12:0] cx, cy;

  always_comb begin
    row      = start_y + YW'(tb);
    colm     = start_x + XW'(ta);
    pix_addr = AW'(32'(row) * FILM_WIDTH + 32'(colm));
    last_a   = (TCW'(ta) + TCW'(1)) == cnt_x;
    last_b   = (TCW'(tb) + TCW'(1)) == cnt_y;
    cx = signed'({1'b0, px}) - signed'({1'b0, origin_x});
    cy = signed'({1'b0, py}) - signed'({1'b0, origin_y});
    read_out = cx < 0 || cy < 0 || cx >= signed'(13'(FILM_WIDTH)) ||
               cy >= signed'(13'(FILM_HEIGHT));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sfsa_pkg::S_CLEAR: begin
        if (clr_cnt == CLRW'(CLR_LEN - 1)) state_next = sfsa_pkg::S_IDLE;
      end
      sfsa_pkg::S_IDLE: begin
        if (item.valid) state_next = sfsa_pkg::S_DECODE;
      end
      sfsa_pkg::S_DECODE: begin
        case (op)
          sfsa_pkg::OP_ADD:  state_next = sfsa_pkg::S_SETUP;
          sfsa_pkg::OP_READ: state_next = read_out ? sfsa_pkg::S_DONE : sfsa_pkg::S_READ;
          default:           state_next = sfsa_pkg::S_DONE;
        endcase
      end
      sfsa_pkg::S_SETUP: begin
        if (ax) state_next = sfsa_pkg::S_IDX_MUL;
      end
      sfsa_pkg::S_IDX_MUL: begin
        if (ax_empty) begin
          if (ax) begin
            state_next = (cnt_x == '0) ? sfsa_pkg::S_DONE : sfsa_pkg::S_DONE;
          end
        end else begin
          state_next = sfsa_pkg::S_IDX_CHK;
        end
      end
      sfsa_pkg::S_IDX_CHK: begin
        if (idx_err) begin
          state_next = sfsa_pkg::S_DONE;
        end else if (!last_tap) begin
          state_next = sfsa_pkg::S_IDX_MUL;
        end else if (!ax) begin
          state_next = sfsa_pkg::S_IDX_MUL;
        end else begin
          state_next = (cnt_x == '0) ? sfsa_pkg::S_DONE : sfsa_pkg::S_PIX_RD;
        end
      end
      sfsa_pkg::S_PIX_RD:  state_next = sfsa_pkg::S_PIX_LAT;
      sfsa_pkg::S_PIX_LAT: state_next = sfsa_pkg::S_PIX_MUL;
      sfsa_pkg::S_PIX_MUL: begin
        if (ch == 3'd4) state_next = sfsa_pkg::S_PIX_WR;
      end
      sfsa_pkg::S_PIX_WR: begin
        if (last_a && last_b) state_next = sfsa_pkg::S_DONE;
        else state_next = sfsa_pkg::S_PIX_RD;
      end
      sfsa_pkg::S_READ:     state_next = sfsa_pkg::S_READ_LAT;
      sfsa_pkg::S_READ_LAT: state_next = sfsa_pkg::S_DONE;
      sfsa_pkg::S_DONE: begin
        if (!out_valid || result.ready) state_next = sfsa_pkg::S_IDLE;
      end
      default: state_next = sfsa_pkg::S_IDLE;
    endcase
  end

  // Memory, multiplier and handshake controls.
  always_comb begin
    item.ready = state == sfsa_pkg::S_IDLE;
    cfg.ready  = 1'b1;
    tab_we     = 1'b0;
    tab_waddr  = TW'(taddr);
    tab_wdata  = tweight;
    tab_raddr  = TW'(32'(yi[tb]) * TABLE_DIM + 32'(xi[ta]));
    film_we    = 1'b0;
    film_waddr = pix_addr;
    film_wdata = {acc[0], acc[1], acc[2], acc[3], accw};
    film_raddr = (state == sfsa_pkg::S_READ) ? rd_addr : pix_addr;
    mul_a      = signed'({1'b0, col[ch[1:0]]});
    mul_b      = wt;
    case (state)
      sfsa_pkg::S_CLEAR: begin
        tab_we     = 32'(clr_cnt) < TABLE_SIZE;
        tab_waddr  = TW'(clr_cnt);
        tab_wdata  = '0;
        film_we    = 32'(clr_cnt) < FILM_SIZE;
        film_waddr = AW'(clr_cnt);
        film_wdata = '0;
      end
      sfsa_pkg::S_DECODE: begin
        tab_we = (op == sfsa_pkg::OP_LOAD) && (32'(taddr) < TABLE_SIZE);
      end
      sfsa_pkg::S_IDX_MUL: begin
        mul_a = 17'(tap_abs);
        mul_b = signed'({2'b00, table_scale});
      end
      sfsa_pkg::S_PIX_WR: begin
        film_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sfsa_pkg::S_CLEAR;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
      half_width   <= 11'd128;
      table_scale  <= 16'd65503;
      clamp_enable <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
      ax           <= 1'b0;
      n            <= '0;
      ta           <= '0;
      tb           <= '0;
      ch           <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          sfsa_pkg::REG_HALF_WIDTH:  half_width   <= cfg.data[10:0];
          sfsa_pkg::REG_TABLE_SCALE: table_scale  <= cfg.data;
          sfsa_pkg::REG_CLAMP:       clamp_enable <= cfg.data[0];
          sfsa_pkg::REG_ORIGIN_X:    origin_x     <= cfg.data[11:0];
          sfsa_pkg::REG_ORIGIN_Y:    origin_y     <= cfg.data[11:0];
          default: begin
          end
        endcase
      end
      // A new result may replace the one taken in the same cycle.
      if (state == sfsa_pkg::S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        sfsa_pkg::S_CLEAR: clr_cnt <= clr_cnt + CLRW'(1);
        sfsa_pkg::S_DECODE: begin
          ax <= 1'b0;
          n  <= '0;
          ta <= '0;
          tb <= '0;
          ch <= '0;
        end
        sfsa_pkg::S_SETUP: ax <= ~ax;
        sfsa_pkg::S_IDX_MUL: begin
          if (ax_empty && !ax) ax <= 1'b1;
        end
        sfsa_pkg::S_IDX_CHK: begin
          if (!idx_err) begin
            if (!last_tap) begin
              n <= n + TIW'(1);
            end else begin
              n  <= '0;
              ax <= 1'b1;
            end
          end
        end
        sfsa_pkg::S_PIX_MUL: ch <= ch + 3'd1;
        sfsa_pkg::S_PIX_WR: begin
          ch <= '0;
          if (last_a) begin
            ta <= '0;
            tb <= tb + TIW'(1);
          end else begin
            ta <= ta + TIW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    case (state)
      sfsa_pkg::S_IDLE: begin
        op      <= item.operation;
        px      <= item.pixel_x;
        py      <= item.pixel_y;
        sx      <= item.sub_x;
        sy      <= item.sub_y;
        taddr   <= item.table_address;
        tweight <= item.table_weight;
        col[0]  <= (clamp_enable && item.red > sfsa_pkg::COLOR_ONE) ?
                   sfsa_pkg::COLOR_ONE : item.red;
        col[1]  <= (clamp_enable && item.green > sfsa_pkg::COLOR_ONE) ?
                   sfsa_pkg::COLOR_ONE : item.green;
        col[2]  <= (clamp_enable && item.blue > sfsa_pkg::COLOR_ONE) ?
                   sfsa_pkg::COLOR_ONE : item.blue;
        col[3]  <= item.alpha;
      end
      sfsa_pkg::S_DECODE: begin
        res_status <= sfsa_pkg::ST_OK;
        for (int k = 0; k < 4; k++) res_sum[k] <= '0;
        res_w   <= '0;
        rd_addr <= AW'(32'(cy[11:0]) * FILM_WIDTH + 32'(cx[11:0]));
        if (op == sfsa_pkg::OP_LOAD && 32'(taddr) >= TABLE_SIZE) begin
          res_status <= sfsa_pkg::ST_INDEX;
        end
        if (op == sfsa_pkg::OP_READ && read_out) res_status <= sfsa_pkg::ST_OUTSIDE;
      end
      sfsa_pkg::S_SETUP: begin
        if (ax) begin
          first_y <= c0;
          cnt_y   <= ax_new_cnt;
          start_y <= YW'(start_rel);
        end else begin
          first_x <= c0;
          cnt_x   <= ax_new_cnt;
          start_x <= XW'(start_rel);
        end
      end
      sfsa_pkg::S_IDX_CHK: begin
        if (idx_err) begin
          res_status <= sfsa_pkg::ST_INDEX;
        end else if (ax) begin
          yi[n] <= IDXW'(mul_p[34:19]);
        end else begin
          xi[n] <= IDXW'(mul_p[34:19]);
        end
      end
      sfsa_pkg::S_PIX_LAT: begin
        wt     <= signed'(tab_rdata);
        acc[0] <= film_rdata[4*SUM_W+WSUM_W-1 -: SUM_W];
        acc[1] <= film_rdata[3*SUM_W+WSUM_W-1 -: SUM_W];
        acc[2] <= film_rdata[2*SUM_W+WSUM_W-1 -: SUM_W];
        acc[3] <= film_rdata[SUM_W+WSUM_W-1 -: SUM_W];
        accw   <= sat_wsum(film_rdata[WSUM_W-1:0], signed'(tab_rdata));
      end
      sfsa_pkg::S_PIX_MUL: begin
        // The product of the previous channel is taken from the registered multiplier.
        if (ch != 3'd0) acc[ch[1:0] - 2'd1] <= sat_sum(acc[ch[1:0] - 2'd1], mul_p);
      end
      sfsa_pkg::S_READ_LAT: begin
        res_sum[0] <= film_rdata[4*SUM_W+WSUM_W-1 -: SUM_W];
        res_sum[1] <= film_rdata[3*SUM_W+WSUM_W-1 -: SUM_W];
        res_sum[2] <= film_rdata[2*SUM_W+WSUM_W-1 -: SUM_W];
        res_sum[3] <= film_rdata[SUM_W+WSUM_W-1 -: SUM_W];
        res_w      <= film_rdata[WSUM_W-1:0];
      end
      sfsa_pkg::S_DONE: begin
        if (!out_valid || result.ready) begin
          out_status <= res_status;
          for (int k = 0; k < 4; k++) out_sum[k] <= res_sum[k];
          out_w <= res_w;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.sum_red    = out_sum[0];
  assign result.sum_green  = out_sum[1];
  assign result.sum_blue   = out_sum[2];
  assign result.sum_alpha  = out_sum[3];
  assign result.sum_weight = out_w;

endmodule
